/* design/rc5_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared constants and types of the RC5 edge decoder: frame length, gap
// classes, phase codes, register map and field positions.
// ----------------------------------------------------------------------------
package rc5_pkg;

	localparam int FRAME_BITS_DEF = 14;

	// gap classes
	typedef logic [1:0] gap_class_t;
	localparam gap_class_t GAP_INVALID = 2'd0;
	localparam gap_class_t GAP_LONG    = 2'd1;
	localparam gap_class_t GAP_SHORT   = 2'd2;

	// decoder phases
	typedef logic [2:0] phase_t;
	localparam phase_t PH_IDLE   = 3'd0;
	localparam phase_t PH_START1 = 3'd1;
	localparam phase_t PH_START2 = 3'd2;
	localparam phase_t PH_TOGGLE = 3'd3;
	localparam phase_t PH_DATA   = 3'd4;
	localparam phase_t PH_SKIP   = 3'd5;

	// register map, index = paddr[3:2]
	localparam int PADDR_W = 4;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LONG_FLOOR  = 2'd0;
	localparam reg_idx_t REG_SHORT_FLOOR = 2'd1;
	localparam reg_idx_t REG_OVF_CEIL    = 2'd2;

	localparam logic [7:0] LONG_FLOOR_RST  = 8'd167;
	localparam logic [7:0] SHORT_FLOOR_RST = 8'd55;
	localparam logic [7:0] OVF_CEIL_RST    = 8'd78;

	// fixed bit positions inside a frame
	localparam int POS_START0 = 0;
	localparam int POS_START1 = 1;
	localparam int POS_TOGGLE = 2;
	localparam int POS_ADDR   = 3;
	localparam int POS_CMD    = 8;
	localparam int ADDR_W     = 5;
	localparam int CMD_W      = 6;

endpackage

`default_nettype wire

/* design/rc5_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5 channel interfaces
// Valid/ready channels for line edges in and decoded frame results out.
// ----------------------------------------------------------------------------
interface rc5_edge_if;
	logic       valid;
	logic       ready;
	logic [7:0] gap_ticks;
	logic       gap_overflow;

	modport source (output valid, output gap_ticks, output gap_overflow, input ready);
	modport sink   (input valid, input gap_ticks, input gap_overflow, output ready);
endinterface

interface rc5_frame_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic       frame_error;
	logic       toggle_flag;
	logic [4:0] device_address;
	logic [5:0] command_code;

	modport source (output valid, output frame_done, output frame_error,
		output toggle_flag, output device_address, output command_code, input ready);
	modport sink   (input valid, input frame_done, input frame_error,
		input toggle_flag, input device_address, input command_code, output ready);
endinterface

`default_nettype wire

/* design/rc5_edge_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_edge_decoder
// RC5 style Manchester frame decoder fed with one infrared line edge per item.
//
//   channel     dir   payload                                   unit
//   edge_in     in    gap_ticks, gap_overflow                   one line edge
//   frame_out   out   frame_done, frame_error, toggle_flag,     one result per edge
//                     device_address, command_code
//   apb         in    long/short gap floor, overflow ceiling    config write/read
//
// One edge per cycle sustained while frame_out is ready; an edge is held in the
// input register, then decoded into the result register.
// The decode state is updated in the same cycle that the result register loads.
// A stalled result holds the input register; edge_in.ready falls only then.
// Reset clears the decode state, the bit store and loads the default limits.
// ----------------------------------------------------------------------------
module rc5_edge_decoder
	import rc5_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rc5_edge_if.sink                edge_in,
	rc5_frame_if.source             frame_out,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int CNT_W = $clog2(FRAME_BITS + 1);
	localparam int IDX_W = $clog2(FRAME_BITS);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);
	localparam logic [CNT_W-1:0] CNT_TOGGLE_NEXT = CNT_W'(POS_TOGGLE + 1);

	// configuration
	logic [7:0] long_floor_q, short_floor_q, ovf_ceil_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_floor_q  <= LONG_FLOOR_RST;
			short_floor_q <= SHORT_FLOOR_RST;
			ovf_ceil_q    <= OVF_CEIL_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LONG_FLOOR:  long_floor_q  <= pwdata[7:0];
				REG_SHORT_FLOOR: short_floor_q <= pwdata[7:0];
				REG_OVF_CEIL:    ovf_ceil_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LONG_FLOOR:  prdata = {24'd0, long_floor_q};
			REG_SHORT_FLOOR: prdata = {24'd0, short_floor_q};
			REG_OVF_CEIL:    prdata = {24'd0, ovf_ceil_q};
			default:         prdata = 32'd0;
		endcase
	end

	// input register
	logic       vld_s1;
	logic [7:0] ticks_s1;
	logic       ovf_s1;
	logic       out_vld_q;
	logic       advance;

	assign advance       = vld_s1 && (!out_vld_q || frame_out.ready);
	assign edge_in.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			vld_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.valid && edge_in.ready) begin
			ticks_s1 <= edge_in.gap_ticks;
			ovf_s1   <= edge_in.gap_overflow;
		end
	end

	// decode state
	phase_t                 phase_q, phase_nx;
	logic [CNT_W-1:0]       bit_idx_q, bit_idx_nx;
	logic [FRAME_BITS-1:0]  bits_q, bits_nx;
	logic                   exp_rise_q, exp_rise_nx;

	gap_class_t             gap;
	logic                   is_short;
	logic                   abort, done;
	logic [CNT_W-1:0]       prev_idx, idx_inc;
	logic                   prev_bit;
	logic                   wr_en, wr_val;
	logic [ADDR_W-1:0]      addr_nx;
	logic [CMD_W-1:0]       cmd_nx;

	always_comb begin
		if (ovf_s1) begin
			gap = (ticks_s1 > ovf_ceil_q) ? GAP_INVALID : GAP_LONG;
		end else if (ticks_s1 > long_floor_q) begin
			gap = GAP_LONG;
		end else if (ticks_s1 >= short_floor_q) begin
			gap = GAP_SHORT;
		end else begin
			gap = GAP_INVALID;
		end
	end

	assign is_short = (gap == GAP_SHORT);
	assign prev_idx = bit_idx_q - CNT_W'(1);
	assign prev_bit = (prev_idx < CNT_FULL) ? bits_q[prev_idx[IDX_W-1:0]] : 1'b0;
	assign idx_inc  = bit_idx_q + CNT_W'(1);

	always_comb begin
		phase_nx   = phase_q;
		bit_idx_nx = bit_idx_q;
		bits_nx    = bits_q;
		abort      = 1'b0;
		done       = 1'b0;
		wr_en      = 1'b0;
		wr_val     = 1'b0;
		if (gap == GAP_INVALID && phase_q != PH_IDLE) begin
			abort = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					bits_nx[POS_START0] = 1'b1;
					phase_nx = PH_START1;
				end
				PH_START1: begin
					if (!is_short) begin
						abort = 1'b1;
					end else begin
						bits_nx[POS_START1] = 1'b1;
						phase_nx = PH_START2;
					end
				end
				PH_START2: begin
					if (!is_short) abort = 1'b1;
					else phase_nx = PH_TOGGLE;
				end
				PH_TOGGLE: begin
					bits_nx[POS_TOGGLE] = is_short;
					phase_nx   = is_short ? PH_SKIP : PH_DATA;
					bit_idx_nx = CNT_TOGGLE_NEXT;
				end
				PH_DATA: begin
					// bit follows previous bit only on the matching edge polarity
					if (!prev_bit && !exp_rise_q) begin
						wr_en  = 1'b1;
						wr_val = !is_short;
					end else if (prev_bit && exp_rise_q) begin
						wr_en  = 1'b1;
						wr_val = is_short;
					end
					if (wr_en && is_short) phase_nx = PH_SKIP;
					if (wr_en && bit_idx_q < CNT_FULL) begin
						bits_nx[bit_idx_q[IDX_W-1:0]] = wr_val;
					end
					bit_idx_nx = idx_inc;
					done = (idx_inc == CNT_FULL);
				end
				PH_SKIP: begin
					phase_nx = PH_DATA;
				end
				default: begin
					abort = 1'b1;
				end
			endcase
		end
		if (abort || done) begin
			phase_nx    = PH_IDLE;
			bit_idx_nx  = '0;
			exp_rise_nx = 1'b0;
		end else begin
			exp_rise_nx = !exp_rise_q;
		end
	end

	assign addr_nx = {bits_nx[POS_ADDR], bits_nx[POS_ADDR+1], bits_nx[POS_ADDR+2],
		bits_nx[POS_ADDR+3], bits_nx[POS_ADDR+4]};
	assign cmd_nx  = {bits_nx[POS_CMD], bits_nx[POS_CMD+1], bits_nx[POS_CMD+2],
		bits_nx[POS_CMD+3], bits_nx[POS_CMD+4], bits_nx[POS_CMD+5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_idx_q  <= '0;
			bits_q     <= '0;
			exp_rise_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_nx;
			bit_idx_q  <= bit_idx_nx;
			bits_q     <= bits_nx;
			exp_rise_q <= exp_rise_nx;
		end
	end

	// result register
	logic              done_q, error_q, toggle_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CMD_W-1:0]  cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q   <= done;
			error_q  <= abort;
			toggle_q <= done && bits_nx[POS_TOGGLE];
			addr_q   <= done ? addr_nx : '0;
			cmd_q    <= done ? cmd_nx : '0;
		end
	end

	assign frame_out.valid          = out_vld_q;
	assign frame_out.frame_done     = done_q;
	assign frame_out.frame_error    = error_q;
	assign frame_out.toggle_flag    = toggle_q;
	assign frame_out.device_address = addr_q;
	assign frame_out.command_code   = cmd_q;

endmodule

`default_nettype wire

/* tb/tb_rc5_edge_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc5_edge_decoder
// Drives line edges into the decoder and checks every frame result against a
// local model of the decode state machine. A short table of edges walks the
// gap limits, start bit aborts and a complete frame. Random frames follow
// under several limit settings. Both channels pause at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_rc5_edge_decoder;
	import rc5_pkg::*;

	typedef struct packed {
		logic       done;
		logic       aborted;
		logic       toggle;
		logic [4:0] address;
		logic [5:0] command;
	} frame_res_t;

	typedef struct packed {
		logic [7:0] ticks;
		logic       ovf;
		logic       fixed;
		frame_res_t res;
	} edge_row_t;

	localparam frame_res_t RES_NONE  = '0;
	localparam frame_res_t RES_ABORT = '{done: 1'b0, aborted: 1'b1, toggle: 1'b0,
		address: 5'd0, command: 6'd0};
	localparam int EDGES_PER_SET = 330;
	localparam int LIMIT_SETS    = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	rc5_edge_if  edge_ch ();
	rc5_frame_if frame_ch ();

	rc5_edge_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_in   (edge_ch),
		.frame_out (frame_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// decoder model state and limits
	phase_t                    dec_phase;
	logic [3:0]                dec_index;
	logic [FRAME_BITS_DEF-1:0] rx_bits;
	logic                      expect_rising;
	logic [7:0]                long_floor;
	logic [7:0]                short_floor;
	logic [7:0]                ovf_ceil;

	frame_res_t frames_due[$];
	int         bad_frames;
	int         edges_sent;
	int         cycle_count;
	int         idle_pct;
	logic       quiet;
	logic       hold_off;

	edge_row_t dir_rows [26] = '{
		'{8'd0,   1'b0, 1'b1, RES_NONE},   // invalid gap still starts a frame
		'{8'd255, 1'b1, 1'b1, RES_ABORT},  // overflow above ceiling
		'{8'd78,  1'b1, 1'b1, RES_NONE},   // overflow at ceiling is long
		'{8'd55,  1'b0, 1'b1, RES_NONE},   // short at floor
		'{8'd168, 1'b0, 1'b1, RES_ABORT},  // long gap in second start bit
		'{8'd128, 1'b0, 1'b1, RES_NONE},
		'{8'd167, 1'b0, 1'b1, RES_NONE},   // short at top of range
		'{8'd55,  1'b0, 1'b1, RES_NONE},
		'{8'd0,   1'b1, 1'b0, RES_NONE},   // long toggle bit
		'{8'd255, 1'b0, 1'b0, RES_NONE},
		'{8'd0,   1'b1, 1'b0, RES_NONE},
		'{8'd78,  1'b1, 1'b0, RES_NONE},
		'{8'd168, 1'b0, 1'b0, RES_NONE},
		'{8'd200, 1'b0, 1'b0, RES_NONE},
		'{8'd255, 1'b0, 1'b0, RES_NONE},
		'{8'd1,   1'b1, 1'b0, RES_NONE},
		'{8'd170, 1'b0, 1'b0, RES_NONE},
		'{8'd255, 1'b0, 1'b0, RES_NONE},
		'{8'd64,  1'b1, 1'b0, RES_NONE},
		'{8'd255, 1'b0, 1'b0, RES_NONE},   // fourteenth bit completes
		'{8'd10,  1'b0, 1'b1, RES_NONE},
		'{8'd100, 1'b0, 1'b1, RES_NONE},
		'{8'd100, 1'b0, 1'b1, RES_NONE},
		'{8'd100, 1'b0, 1'b0, RES_NONE},   // short toggle bit
		'{8'd100, 1'b0, 1'b0, RES_NONE},   // mid-bit skip
		'{8'd54,  1'b0, 1'b1, RES_ABORT}   // too short in data phase
	};

	function automatic gap_class_t classify_gap(logic [7:0] ticks, logic ovf);
		if (ovf)
			return (ticks > ovf_ceil) ? GAP_INVALID : GAP_LONG;
		if (ticks > long_floor)
			return GAP_LONG;
		if (ticks >= short_floor)
			return GAP_SHORT;
		return GAP_INVALID;
	endfunction

	function automatic void back_to_idle();
		dec_phase     = PH_IDLE;
		dec_index     = 4'd0;
		expect_rising = 1'b0;
	endfunction

	function automatic frame_res_t decode_edge(logic [7:0] ticks, logic ovf);
		gap_class_t gap;
		logic       is_short;
		logic       abort;
		logic       done;
		logic       prev;
		logic [3:0] cur;
		logic [3:0] prev_idx;
		frame_res_t res;
		gap      = classify_gap(ticks, ovf);
		is_short = (gap == GAP_SHORT);
		abort    = 1'b0;
		done     = 1'b0;
		res      = RES_NONE;
		if (gap == GAP_INVALID && dec_phase != PH_IDLE) begin
			abort = 1'b1;
		end else begin
			case (dec_phase)
				PH_IDLE: begin
					rx_bits[POS_START0] = 1'b1;
					dec_phase = PH_START1;
				end
				PH_START1: begin
					if (!is_short) begin
						abort = 1'b1;
					end else begin
						rx_bits[POS_START1] = 1'b1;
						dec_phase = PH_START2;
					end
				end
				PH_START2: begin
					if (!is_short)
						abort = 1'b1;
					else
						dec_phase = PH_TOGGLE;
				end
				PH_TOGGLE: begin
					rx_bits[POS_TOGGLE] = is_short;
					dec_phase = is_short ? PH_SKIP : PH_DATA;
					dec_index = 4'd3;
				end
				PH_DATA: begin
					cur      = dec_index;
					prev_idx = cur - 4'd1;
					prev     = (prev_idx < FRAME_BITS_DEF) ? rx_bits[prev_idx] : 1'b0;
					// bit only updates when edge polarity matches previous bit
					if (prev == expect_rising) begin
						if (cur < FRAME_BITS_DEF)
							rx_bits[cur] = is_short ? prev : ~prev;
						if (is_short)
							dec_phase = PH_SKIP;
					end
					dec_index = cur + 4'd1;
					done = (dec_index == FRAME_BITS_DEF);
				end
				PH_SKIP: begin
					dec_phase = PH_DATA;
				end
				default: begin
					abort = 1'b1;
				end
			endcase
		end
		if (abort) begin
			back_to_idle();
			res.aborted = 1'b1;
		end else if (done) begin
			res.done   = 1'b1;
			res.toggle = rx_bits[POS_TOGGLE];
			for (int k = 0; k < ADDR_W; k++)
				res.address[ADDR_W-1-k] = rx_bits[POS_ADDR+k];
			for (int k = 0; k < CMD_W; k++)
				res.command[CMD_W-1-k] = rx_bits[POS_CMD+k];
			back_to_idle();
		end else begin
			expect_rising = ~expect_rising;
		end
		return res;
	endfunction

	// mostly well-formed frames, a little noise
	function automatic void choose_gap(output logic [7:0] ticks, output logic ovf);
		gap_class_t cls;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 2)
			cls = GAP_INVALID;
		else if (dec_phase == PH_IDLE)
			cls = GAP_INVALID;
		else if (dec_phase == PH_START1 || dec_phase == PH_START2)
			cls = (r < 10) ? GAP_LONG : GAP_SHORT;
		else
			cls = $urandom_range(1) ? GAP_LONG : GAP_SHORT;
		ovf   = 1'b0;
		ticks = 8'($urandom_range(255));
		// invalid class here means any value at all
		case (cls)
			GAP_SHORT: begin
				if (short_floor <= long_floor)
					ticks = 8'($urandom_range(int'(long_floor), int'(short_floor)));
			end
			GAP_LONG: begin
				if (long_floor == 8'hff || $urandom_range(1)) begin
					ovf   = 1'b1;
					ticks = 8'($urandom_range(int'(ovf_ceil)));
				end else begin
					ticks = 8'($urandom_range(255, int'(long_floor) + 1));
				end
			end
			default: begin
				ovf = 1'($urandom_range(1));
			end
		endcase
	endfunction

	function automatic void note_bad(string what, frame_res_t want, frame_res_t got);
		bad_frames++;
		if (bad_frames <= MAX_REPORTS)
			$display("%0t %s: expected done=%0b err=%0b toggle=%0b addr=%0d cmd=%0d, %s",
				$realtime, what, want.done, want.aborted, want.toggle, want.address,
				want.command, $sformatf("got done=%0b err=%0b toggle=%0b addr=%0d cmd=%0d",
				got.done, got.aborted, got.toggle, got.address, got.command));
	endfunction

	task automatic send_edge(input logic [7:0] ticks, input logic ovf, input logic fixed,
		input frame_res_t fixed_res);
		frame_res_t res;
		edge_ch.valid        <= 1'b1;
		edge_ch.gap_ticks    <= ticks;
		edge_ch.gap_overflow <= ovf;
		do @(posedge clk); while (edge_ch.ready !== 1'b1);
		res = decode_edge(ticks, ovf);
		frames_due.push_back(fixed ? fixed_res : res);
		edges_sent++;
		if (!quiet && $urandom_range(99) < idle_pct) begin
			edge_ch.valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_frames();
		edge_ch.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// psel/penable are left up so that writes can follow back to back
	task automatic write_limit(input reg_idx_t idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_LONG_FLOOR:  long_floor  = val;
			REG_SHORT_FLOOR: short_floor = val;
			REG_OVF_CEIL:    ovf_ceil    = val;
			default: ;
		endcase
	endtask

	task automatic apply_limits(input logic [7:0] lf, input logic [7:0] sf, input logic [7:0] oc);
		drain_frames();
		write_limit(REG_LONG_FLOOR, lf);
		write_limit(REG_SHORT_FLOOR, sf);
		write_limit(REG_OVF_CEIL, oc);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// one long receiver hold-off while the sender keeps offering
	initial begin
		hold_off <= 1'b0;
		wait (edges_sent >= 900);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// result side: check each transfer, then pick next ready
	initial begin
		int unsigned stall;
		frame_res_t  got;
		stall = 0;
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
				got = {frame_ch.frame_done, frame_ch.frame_error, frame_ch.toggle_flag,
					frame_ch.device_address, frame_ch.command_code};
				if (frames_due.size() == 0) begin
					note_bad("result with nothing pending", RES_NONE, got);
				end else if (got.done !== frames_due[0].done
					|| got.aborted !== frames_due[0].aborted
					|| got.toggle !== frames_due[0].toggle
					|| got.address !== frames_due[0].address
					|| got.command !== frames_due[0].command) begin
					note_bad("frame mismatch", frames_due.pop_front(), got);
				end else begin
					void'(frames_due.pop_front());
				end
			end
			if (hold_off) begin
				frame_ch.ready <= 1'b0;
			end else if (stall != 0) begin
				frame_ch.ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(99) < idle_pct) begin
				frame_ch.ready <= 1'b0;
				stall = $urandom_range(7);
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] ticks;
		logic       ovf;
		logic [7:0] lf;
		logic [7:0] sf;
		logic [7:0] oc;
		arst_n               <= 1'b0;
		edge_ch.valid        <= 1'b0;
		edge_ch.gap_ticks    <= 8'd0;
		edge_ch.gap_overflow <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= 32'd0;
		quiet                <= 1'b0;
		idle_pct             <= 20;
		cycle_count          = 0;
		bad_frames           = 0;
		edges_sent           = 0;
		long_floor           = LONG_FLOOR_RST;
		short_floor          = SHORT_FLOOR_RST;
		ovf_ceil             = OVF_CEIL_RST;
		rx_bits              = '0;
		back_to_idle();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_edge(dir_rows[i].ticks, dir_rows[i].ovf, dir_rows[i].fixed, dir_rows[i].res);

		for (int set = 0; set < LIMIT_SETS; set++) begin
			case (set)
				0: begin
					lf = LONG_FLOOR_RST;
					sf = SHORT_FLOOR_RST;
					oc = OVF_CEIL_RST;
				end
				1: {lf, sf, oc} = '0;
				2: {lf, sf, oc} = '1;
				4: begin
					// every plain gap short, overflow never invalid
					lf = 8'hff;
					sf = 8'h00;
					oc = 8'hff;
				end
				default: begin
					lf = 8'($urandom_range(255, 96));
					sf = 8'($urandom_range(95));
					oc = 8'($urandom);
				end
			endcase
			apply_limits(lf, sf, oc);
			case (set)
				1:       idle_pct <= 0;
				2:       idle_pct <= 35;
				3:       idle_pct <= 15;
				default: idle_pct <= 25;
			endcase
			if (set == LIMIT_SETS - 1)
				quiet <= 1'b1;
			repeat (EDGES_PER_SET) begin
				choose_gap(ticks, ovf);
				send_edge(ticks, ovf, 1'b0, RES_NONE);
			end
		end

		drain_frames();
		repeat (10) @(posedge clk);
		if (bad_frames == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
